>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL top module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/lmdrf_pkg.sv
// ----------------------------------------------------------------------------
// lmdrf_pkg
// Types and constants of the LED matrix dirty row flush block.
// ----------------------------------------------------------------------------
package lmdrf_pkg;

   localparam int ROWS_PER_MODULE = 8;
   localparam int X_W             = 5;
   localparam int Y_W             = 3;
   localparam int COL_W           = 3;
   localparam int MOD_IDX_W       = 2;
   localparam int ROW_REG_W       = 4;
   localparam int ROW_BITS_W      = 8;

   localparam logic OP_SET   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Pixel update request handed to the bit unit.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             on;
   } set_op_type;

   // Updated row byte and whether any bit moved.
   typedef struct packed {
      logic [ROW_BITS_W-1:0] row_bits;
      logic                  changed;
   } upd_type;

endpackage

>>> src/lmdrf_req_if.sv
// ----------------------------------------------------------------------------
// lmdrf_req_if
// Request channel: one set-pixel or flush word per handshake.
// ----------------------------------------------------------------------------
interface lmdrf_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [lmdrf_pkg::X_W-1:0]   pixel_x;
   logic [lmdrf_pkg::Y_W-1:0]   pixel_y;
   logic                        pixel_on;

   modport source (output valid, output op, output pixel_x, output pixel_y,
                   output pixel_on, input ready);
   modport sink   (input valid, input op, input pixel_x, input pixel_y,
                   input pixel_on, output ready);
endinterface

>>> src/lmdrf_rsp_if.sv
// ----------------------------------------------------------------------------
// lmdrf_rsp_if
// Response channel: one module frame per handshake.
// ----------------------------------------------------------------------------
interface lmdrf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lmdrf_pkg::MOD_IDX_W-1:0]   module_index;
   logic [lmdrf_pkg::ROW_REG_W-1:0]   row_register;
   logic [lmdrf_pkg::ROW_BITS_W-1:0]  row_bits;
   logic                              end_of_transfer;
   logic                              last;

   modport source (output valid, output module_index, output row_register,
                   output row_bits, output end_of_transfer, output last,
                   input ready);
   modport sink   (input valid, input module_index, input row_register,
                   input row_bits, input end_of_transfer, input last,
                   output ready);
endinterface

>>> src/lmdrf_ram.sv
// ----------------------------------------------------------------------------
// lmdrf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lmdrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lmdrf_bit_unit.sv
// ----------------------------------------------------------------------------
// lmdrf_bit_unit
// Sets or clears one pixel in a stored row byte and flags a change.
// ----------------------------------------------------------------------------
module lmdrf_bit_unit (
   input  logic [lmdrf_pkg::ROW_BITS_W-1:0] old_bits,
   input  lmdrf_pkg::set_op_type            set_op,
   output lmdrf_pkg::upd_type               upd
);

   logic [lmdrf_pkg::ROW_BITS_W-1:0] bit_mask;
   logic [lmdrf_pkg::ROW_BITS_W-1:0] new_bits;

   // Column 0 sits in the most significant bit.
   assign bit_mask = 8'h80 >> set_op.col;
   assign new_bits = set_op.on ? (old_bits | bit_mask) : (old_bits & ~bit_mask);

   assign upd.row_bits = new_bits;
   assign upd.changed  = (new_bits != old_bits);

endmodule

>>> src/led_matrix_dirty_row_flush.sv
// ----------------------------------------------------------------------------
// led_matrix_dirty_row_flush
// Frame buffer for a chain of cascaded 8x8 LED matrix modules that refreshes
// only the rows that changed.
// ----------------------------------------------------------------------------
// The req channel carries one word per item. A set word (op low) writes one
// pixel; a pixel off the grid is ignored and rewriting the stored value marks
// nothing dirty. A flush word (op high) walks local rows 0 to 7 and, for every
// dirty row, sends one frame word per module on the rsp channel, in module
// order, then clears that row's dirty flag.
// A set word reads the row byte from the RAM, then updates it through the bit
// unit and writes it back. A flush takes the word, then scans the rows in
// turn, dirty or clean, up to the last dirty row (all eight rows when none is
// dirty); each frame word is read from the RAM and then held in the output
// register, longer when the receiver stalls. The single RAM port and the
// sequencer set this order; req.ready is high only while the block is idle.
// After reset the block clears the pixel RAM one entry per cycle, all
// 8 * MODULES_ACROSS * MODULES_DOWN entries, and does not accept words until
// that pass is done. When the receiver holds rsp.ready low, the frame word
// stays put and the sequencer waits; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_matrix_dirty_row_flush #(
   parameter int MODULES_ACROSS = 4,
   parameter int MODULES_DOWN   = 1
) (
   input  logic             clock,
   input  logic             reset,
   lmdrf_req_if.sink        req,
   lmdrf_rsp_if.source      rsp
);

   // Sizes of the module chain and the pixel store.
   localparam int MODULE_COUNT = MODULES_ACROSS * MODULES_DOWN;
   localparam int DEPTH        = MODULE_COUNT * lmdrf_pkg::ROWS_PER_MODULE;
   localparam int AW           = $clog2(DEPTH);
   localparam int MW           = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;
   localparam int COLS         = 8 * MODULES_ACROSS;

   localparam logic [AW-1:0] LAST_ADDR   = AW'(DEPTH - 1);
   localparam logic [MW-1:0] LAST_MODULE = MW'(MODULE_COUNT - 1);
   localparam logic [7:0]    COLS_W      = 8'(COLS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET,
      ST_SCAN,
      ST_READ,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   // Clearing counter during the reset pass, target address of a set.
   logic [AW-1:0] addr_ff, addr_in;
   // Local row being flushed, or row of the pending set.
   logic [2:0]    row_ff, row_in;
   logic [MW-1:0] mod_ff, mod_in;
   logic [7:0]    dirty_ff, dirty_in;
   lmdrf_pkg::set_op_type set_op_ff, set_op_in;

   // Output register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [lmdrf_pkg::MOD_IDX_W-1:0]     rsp_module_ff, rsp_module_in;
   logic [lmdrf_pkg::ROW_REG_W-1:0]     rsp_rowreg_ff, rsp_rowreg_in;
   logic [lmdrf_pkg::ROW_BITS_W-1:0]    rsp_bits_ff, rsp_bits_in;
   logic                                rsp_eot_ff, rsp_eot_in;
   logic                                rsp_last_ff, rsp_last_in;

   // RAM port signals.
   logic                                ram_wr_en;
   logic [AW-1:0]                       ram_wr_addr;
   logic [lmdrf_pkg::ROW_BITS_W-1:0]    ram_wr_data;
   logic                                ram_rd_en;
   logic [AW-1:0]                       ram_rd_addr;
   logic [lmdrf_pkg::ROW_BITS_W-1:0]    ram_rd_data;

   lmdrf_pkg::upd_type upd;

   logic       on_grid;
   logic [7:0] above_mask;
   logic       frame_eot;

   lmdrf_ram #(
      .WIDTH (lmdrf_pkg::ROW_BITS_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lmdrf_bit_unit u_bit_unit (
      .old_bits (ram_rd_data),
      .set_op   (set_op_ff),
      .upd      (upd)
   );

   assign req.ready = (state_ff == ST_IDLE);

   // The pixel row field is three bits wide, so every row lies in the first
   // band of modules and only the column can leave the grid.
   assign on_grid = ({3'b000, req.pixel_x} < COLS_W);

   // Rows strictly above the current one; tells whether this frame is final.
   assign above_mask = ~((8'd2 << row_ff) - 8'd1);
   assign frame_eot  = (mod_ff == LAST_MODULE);

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      row_in        = row_ff;
      mod_in        = mod_ff;
      dirty_in      = dirty_ff;
      set_op_in     = set_op_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_module_in = rsp_module_ff;
      rsp_rowreg_in = rsp_rowreg_ff;
      rsp_bits_in   = rsp_bits_ff;
      rsp_eot_in    = rsp_eot_ff;
      rsp_last_in   = rsp_last_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'({mod_ff, row_ff});

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            addr_in   = addr_ff + AW'(1);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               if (req.op == lmdrf_pkg::OP_FLUSH) begin
                  row_in   = 3'd0;
                  state_in = ST_SCAN;
               end else if (on_grid) begin
                  addr_in       = AW'({req.pixel_x[4:3], req.pixel_y});
                  row_in        = req.pixel_y;
                  set_op_in.col = req.pixel_x[2:0];
                  set_op_in.on  = req.pixel_on;
                  ram_rd_en     = 1'b1;
                  ram_rd_addr   = AW'({req.pixel_x[4:3], req.pixel_y});
                  state_in      = ST_SET;
               end
            end
         end
         ST_SET: begin
            // Write back only when the pixel really changed.
            if (upd.changed) begin
               ram_wr_en        = 1'b1;
               ram_wr_data      = upd.row_bits;
               dirty_in[row_ff] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (dirty_ff[row_ff]) begin
               mod_in      = '0;
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'({{MW{1'b0}}, row_ff});
               state_in    = ST_READ;
            end else if (row_ff == 3'd7) begin
               state_in = ST_IDLE;
            end else begin
               row_in = row_ff + 3'd1;
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_module_in = lmdrf_pkg::MOD_IDX_W'(mod_ff);
            rsp_rowreg_in = {1'b0, row_ff} + 4'd1;
            rsp_bits_in   = ram_rd_data;
            rsp_eot_in    = frame_eot;
            rsp_last_in   = frame_eot && ((dirty_ff & above_mask) == 8'd0);
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_eot_ff) begin
                  dirty_in[row_ff] = 1'b0;
                  if (rsp_last_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     row_in   = row_ff + 3'd1;
                     state_in = ST_SCAN;
                  end
               end else begin
                  mod_in      = mod_ff + MW'(1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = AW'({mod_ff + MW'(1), row_ff});
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      set_op_ff     <= set_op_in;
      rsp_module_ff <= rsp_module_in;
      rsp_rowreg_ff <= rsp_rowreg_in;
      rsp_bits_ff   <= rsp_bits_in;
      rsp_eot_ff    <= rsp_eot_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         row_ff       <= '0;
         mod_ff       <= '0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         row_ff       <= row_in;
         mod_ff       <= mod_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.module_index    = rsp_module_ff;
   assign rsp.row_register    = rsp_rowreg_ff;
   assign rsp.row_bits        = rsp_bits_ff;
   assign rsp.end_of_transfer = rsp_eot_ff;
   assign rsp.last            = rsp_last_ff;

   `ASSERT_SAME(a_valid_in_out, clock, reset, rsp_valid_ff, state_ff == ST_OUT,
      "frame word shown outside output state")
   `ASSERT_SAME(a_last_ends_row, clock, reset, rsp.valid && rsp.last,
      rsp.end_of_transfer, "last frame does not end a row")
   `ASSERT_NEXT(a_set_reads, clock, reset,
      req.valid && req.ready && (req.op == lmdrf_pkg::OP_SET) && on_grid,
      state_ff == ST_SET, "set word did not start a read")
   `ASSERT_NEXT(a_dirty_cleared, clock, reset,
      rsp.valid && rsp.ready && rsp.end_of_transfer,
      !dirty_ff[$past(row_ff)], "flushed row still dirty")

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED matrix dirty row flush block. A short table
// of pixel writes and flushes exercises the corner cases, and then random
// bursts of writes, each closed by a flush, run under four idling patterns.
// Every frame word that comes back is compared field by field against the
// table's own frames or a behavioral copy of the frame buffer in the bench.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS_PER_MODULE = lmdrf_pkg::ROWS_PER_MODULE;
   localparam int X_W             = lmdrf_pkg::X_W;
   localparam int Y_W             = lmdrf_pkg::Y_W;
   localparam int MOD_IDX_W       = lmdrf_pkg::MOD_IDX_W;
   localparam int ROW_REG_W       = lmdrf_pkg::ROW_REG_W;
   localparam int ROW_BITS_W      = lmdrf_pkg::ROW_BITS_W;
   localparam logic OP_SET        = lmdrf_pkg::OP_SET;
   localparam logic OP_FLUSH      = lmdrf_pkg::OP_FLUSH;

   localparam int MODULES_ACROSS = 4;
   localparam int MODULES_DOWN   = 1;
   localparam int MODULE_COUNT   = MODULES_ACROSS * MODULES_DOWN;
   localparam int STORE_DEPTH    = MODULE_COUNT * ROWS_PER_MODULE;
   localparam int ITEMS_TOTAL    = 450;
   // A full flush is 32 frames, so this is ample for any stray frame word to
   // show up after the last expected one.
   localparam int DRAIN_CYCLES   = 200;
   // This limit leaves a wide margin on top of the slowest legal run and the
   // clearing pass after reset.
   localparam int CYCLE_LIMIT    = 400000;

   // One frame word as it appears on the response channel.
   typedef struct packed {
      logic [MOD_IDX_W-1:0]  module_index;
      logic [ROW_REG_W-1:0]  row_register;
      logic [ROW_BITS_W-1:0] row_bits;
      logic                  end_of_transfer;
      logic                  last;
   } frame_type;

   // One row of the directed table. When typed is set on a flush, the frames
   // are spelled out here: either none, or one dirty row whose bytes for
   // modules 0 to 3 are given in t_bits. Other rows use the frame buffer copy.
   typedef struct packed {
      logic                                    op;
      logic [X_W-1:0]                          pixel_x;
      logic [Y_W-1:0]                          pixel_y;
      logic                                    pixel_on;
      logic                                    typed;
      logic                                    has_row;
      logic [Y_W-1:0]                          t_row;
      logic [0:MODULE_COUNT-1][ROW_BITS_W-1:0] t_bits;
   } directed_type;

   localparam logic [0:MODULE_COUNT-1][ROW_BITS_W-1:0] NO_BITS = '0;
   localparam int NUM_DIRECTED = 23;

   directed_type directed_tbl [NUM_DIRECTED] = '{
      // A flush straight after reset finds nothing dirty.
      '{OP_FLUSH, 5'd0,  3'd0, 1'b0, 1'b1, 1'b0, 3'd0, NO_BITS},
      // Top left pixel lands in the MSB of module 0, row register 1.
      '{OP_SET,   5'd0,  3'd0, 1'b1, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_FLUSH, 5'd0,  3'd0, 1'b0, 1'b1, 1'b1, 3'd0,
        {8'h80, 8'h00, 8'h00, 8'h00}},
      // Writing the same value again leaves the row clean.
      '{OP_SET,   5'd0,  3'd0, 1'b1, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_FLUSH, 5'd0,  3'd0, 1'b0, 1'b1, 1'b0, 3'd0, NO_BITS},
      // Bottom right pixel lands in the LSB of the last module, register 8.
      '{OP_SET,   5'd31, 3'd7, 1'b1, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_FLUSH, 5'd0,  3'd0, 1'b0, 1'b1, 1'b1, 3'd7,
        {8'h00, 8'h00, 8'h00, 8'h01}},
      // Clearing it again is a change and dirties the row once more.
      '{OP_SET,   5'd31, 3'd7, 1'b0, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_FLUSH, 5'd0,  3'd0, 1'b0, 1'b1, 1'b1, 3'd7, NO_BITS},
      // Module boundaries: last column of one module, first of the next.
      '{OP_SET,   5'd7,  3'd3, 1'b1, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_SET,   5'd8,  3'd3, 1'b1, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_SET,   5'd23, 3'd3, 1'b1, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_SET,   5'd24, 3'd3, 1'b1, 1'b0, 1'b0, 3'd0, NO_BITS},
      // The pixel fields of a flush word carry no meaning, so set them all.
      '{OP_FLUSH, 5'd31, 3'd7, 1'b1, 1'b1, 1'b1, 3'd3,
        {8'h01, 8'h80, 8'h01, 8'h80}},
      // A pixel toggled on and back off still leaves its row dirty.
      '{OP_SET,   5'd0,  3'd0, 1'b0, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_SET,   5'd16, 3'd5, 1'b1, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_SET,   5'd16, 3'd5, 1'b0, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_FLUSH, 5'd31, 3'd7, 1'b1, 1'b0, 1'b0, 3'd0, NO_BITS},
      // Several rows dirty in one flush.
      '{OP_SET,   5'd12, 3'd1, 1'b1, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_SET,   5'd19, 3'd6, 1'b1, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_SET,   5'd27, 3'd2, 1'b1, 1'b0, 1'b0, 3'd0, NO_BITS},
      '{OP_FLUSH, 5'd21, 3'd5, 1'b0, 1'b0, 1'b0, 3'd0, NO_BITS},
      // Back to back flushes: the second one has nothing left to send.
      '{OP_FLUSH, 5'd10, 3'd2, 1'b1, 1'b1, 1'b0, 3'd0, NO_BITS}
   };

   logic clock = 1'b0;
   logic reset;

   lmdrf_req_if req_ch ();
   lmdrf_rsp_if rsp_ch ();

   led_matrix_dirty_row_flush #(
      .MODULES_ACROSS (MODULES_ACROSS),
      .MODULES_DOWN   (MODULES_DOWN)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #4 clock = ~clock;

   // Bench copy of the frame buffer: one byte per module row, bit 7 being
   // the leftmost column, plus one dirty flag per module-local row.
   logic [ROW_BITS_W-1:0] pix_store [STORE_DEPTH];
   logic [ROWS_PER_MODULE-1:0] dirty_rows;

   frame_type expected_frames [$];   // frame words still owed by the block
   frame_type flush_plan [$];        // frames worked out for the latest flush

   int idle_pct    = 0;           // chance in a hundred that the sender idles
   int stall_pct   = 0;           // chance in a hundred that the receiver stalls
   int error_count = 0;
   int cycle_count = 0;
   int words_sent     = 0;
   int frames_checked = 0;
   int flush_count    = 0;
   int clean_flushes  = 0;
   int deepest_flush  = 0;

   // Store entry of a global pixel, or -1 when the pixel lies off the grid.
   function automatic int pixel_index(input logic [X_W-1:0] x,
                                      input logic [Y_W-1:0] y);
      int xi;
      int yi;
      xi = int'(x);
      yi = int'(y);
      if (xi >= 8 * MODULES_ACROSS || yi >= 8 * MODULES_DOWN)
         return -1;
      return ((yi / 8) * MODULES_ACROSS + xi / 8) * ROWS_PER_MODULE + yi % 8;
   endfunction

   function automatic logic stored_pixel(input logic [X_W-1:0] x,
                                         input logic [Y_W-1:0] y);
      int idx;
      idx = pixel_index(x, y);
      if (idx < 0)
         return 1'b0;
      return pix_store[idx][7 - int'(x) % 8];
   endfunction

   // A pixel write only dirties its row when the stored bit actually moves.
   function automatic void apply_set(input logic [X_W-1:0] x,
                                     input logic [Y_W-1:0] y,
                                     input logic on);
      int idx;
      logic [ROW_BITS_W-1:0] updated;
      idx = pixel_index(x, y);
      if (idx >= 0) begin
         updated = pix_store[idx];
         updated[7 - int'(x) % 8] = on;
         if (updated != pix_store[idx]) begin
            pix_store[idx] = updated;
            dirty_rows[int'(y) % 8] = 1'b1;
         end
      end
   endfunction

   // Walks local rows 0 to 7 and lists one frame per module for every dirty
   // row, clearing the flag as it goes. The final frame carries last.
   function automatic void plan_flush();
      frame_type f;
      flush_plan.delete();
      for (int r = 0; r < ROWS_PER_MODULE; r++) begin
         if (dirty_rows[r]) begin
            for (int m = 0; m < MODULE_COUNT; m++) begin
               f.module_index    = MOD_IDX_W'(m);
               f.row_register    = ROW_REG_W'(r + 1);
               f.row_bits        = pix_store[m * ROWS_PER_MODULE + r];
               f.end_of_transfer = (m == MODULE_COUNT - 1);
               f.last            = 1'b0;
               flush_plan.push_back(f);
            end
            dirty_rows[r] = 1'b0;
         end
      end
      if (flush_plan.size() > 0) begin
         f = flush_plan.pop_back();
         f.last = 1'b1;
         flush_plan.push_back(f);
      end else begin
         clean_flushes++;
      end
      flush_count++;
      if (flush_plan.size() > deepest_flush)
         deepest_flush = flush_plan.size();
   endfunction

   // Drives one request word and returns once it has been accepted. The
   // valid line is only lowered while the sender idles, so back to back
   // words keep it high without a second assignment in the same step.
   task automatic send_word(input logic op, input logic [X_W-1:0] x,
                            input logic [Y_W-1:0] y, input logic on);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.op       <= op;
      req_ch.pixel_x  <= x;
      req_ch.pixel_y  <= y;
      req_ch.pixel_on <= on;
      do
         @(posedge clock);
      while (!req_ch.ready);
      words_sent++;
   endtask

   // Sends a word and books whatever frames the frame buffer copy predicts.
   task automatic issue(input logic op, input logic [X_W-1:0] x,
                        input logic [Y_W-1:0] y, input logic on);
      send_word(op, x, y, on);
      if (op == OP_SET) begin
         apply_set(x, y, on);
      end else begin
         plan_flush();
         foreach (flush_plan[i])
            expected_frames.push_back(flush_plan[i]);
      end
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Response side: every accepted frame word is matched against the oldest
   // one still owed. Values are read before this edge's updates land, so the
   // comparison sees exactly what was on the wires at the handshake.
   always @(posedge clock) begin : frame_monitor
      frame_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_frames.size() == 0) begin
            $error("frame word with nothing expected: module %0d row reg %0d",
                   rsp_ch.module_index, rsp_ch.row_register);
            error_count++;
         end else begin
            want = expected_frames.pop_front();
            check_field("module_index", want.module_index, rsp_ch.module_index);
            check_field("row_register", want.row_register, rsp_ch.row_register);
            check_field("row_bits", want.row_bits, rsp_ch.row_bits);
            check_field("end_of_transfer", want.end_of_transfer,
                        rsp_ch.end_of_transfer);
            check_field("last", want.last, rsp_ch.last);
            frames_checked++;
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d frame words outstanding",
                  cycle_count, expected_frames.size());
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      directed_type e;
      frame_type f;
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      logic on;
      int burst;
      int phase_idx;

      // Known values on every input before the first edge.
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.op       = OP_SET;
      req_ch.pixel_x  = '0;
      req_ch.pixel_y  = '0;
      req_ch.pixel_on = 1'b0;
      rsp_ch.ready    = 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++)
         pix_store[i] = '0;
      dirty_rows = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table, run with both sides always ready. The block clears
      // its pixel RAM after reset; the first handshake simply waits for it.
      foreach (directed_tbl[i]) begin
         e = directed_tbl[i];
         if (e.op == OP_FLUSH && e.typed) begin
            send_word(e.op, e.pixel_x, e.pixel_y, e.pixel_on);
            plan_flush();   // keeps the dirty flags in step with the block
            if (e.has_row) begin
               for (int m = 0; m < MODULE_COUNT; m++) begin
                  f.module_index    = MOD_IDX_W'(m);
                  f.row_register    = {1'b0, e.t_row} + 4'd1;
                  f.row_bits        = e.t_bits[m];
                  f.end_of_transfer = (m == MODULE_COUNT - 1);
                  f.last            = (m == MODULE_COUNT - 1);
                  expected_frames.push_back(f);
               end
            end
         end else begin
            issue(e.op, e.pixel_x, e.pixel_y, e.pixel_on);
         end
      end

      // Random part: bursts of pixel writes, each closed by a flush. The
      // words are split into four stretches with different idling patterns.
      while (words_sent < ITEMS_TOTAL) begin
         phase_idx = (words_sent - NUM_DIRECTED) * 4 / (ITEMS_TOTAL - NUM_DIRECTED + 1);
         case (phase_idx)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 76;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 76;
            end
            default: begin
               idle_pct  = 6;
               stall_pct = 6;
            end
         endcase

         if ($urandom_range(5) == 0) begin
            // Touch every local row so the flush runs its full 32 frames.
            for (int r = 0; r < ROWS_PER_MODULE; r++) begin
               x = X_W'($urandom);
               y = Y_W'(r);
               issue(OP_SET, x, y, ~stored_pixel(x, y));
            end
         end else begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
               x = X_W'($urandom);
               y = Y_W'($urandom);
               // About a third of the writes repeat the stored value.
               if ($urandom_range(2) == 0)
                  on = stored_pixel(x, y);
               else
                  on = 1'($urandom_range(1));
               issue(OP_SET, x, y, on);
            end
         end

         issue(OP_FLUSH, X_W'($urandom), Y_W'($urandom), 1'($urandom_range(1)));
         if ($urandom_range(3) == 0)
            issue(OP_FLUSH, X_W'($urandom), Y_W'($urandom), 1'($urandom_range(1)));
      end

      // The last word has been accepted; drop valid and let the block drain.
      req_ch.valid <= 1'b0;
      idle_pct  = 0;
      stall_pct = 0;
      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request words, %0d flushes (%0d found nothing dirty)",
               words_sent, flush_count, clean_flushes);
      $display("compared %0d frame words, longest flush %0d frames, %0d mismatches",
               frames_checked, deepest_flush, error_count);
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
